>>> src/delimited_frame_unstuffer_assert.svh
// Assertion macros used by the deframer top file.
`ifndef DELIMITED_FRAME_UNSTUFFER_ASSERT_SVH
`define DELIMITED_FRAME_UNSTUFFER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dfu_pkg.sv
package dfu_pkg;

	localparam int CNT_W = 8;
	localparam int BYTE_W = 8;
	localparam int IDX_W = 7;
	localparam int SIZE_W = 16;
	localparam int MAX_STUFFED_BYTES_DEF = 128;

	localparam logic [BYTE_W-1:0] DELIM = 8'h12;
	localparam logic [BYTE_W-1:0] ESC = 8'hDB;
	localparam logic [BYTE_W-1:0] ESC_DELIM = 8'hDE;
	localparam logic [BYTE_W-1:0] ESC_ESC = 8'hDD;
	localparam logic [CNT_W-1:0] MIN_STUFFED = 8'd8;
	localparam logic [SIZE_W-1:0] MIN_SIZE = 16'd8;
	localparam logic [SIZE_W:0] SIZE_OVERHEAD = 17'd3;

	typedef enum logic [2:0] {
		KIND_DATA = 3'd0,
		KIND_GOOD = 3'd1,
		KIND_BAD_SIZE = 3'd2,
		KIND_SHORT = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [BYTE_W-1:0] data_byte;
		logic [IDX_W-1:0] byte_index;
		logic [CNT_W-1:0] frame_length;
	} result_t;

	typedef struct packed {
		logic hunting;
		logic escape_pending;
		logic [CNT_W-1:0] stuffed_count;
		logic [CNT_W-1:0] unstuffed_count;
	} status_t;

endpackage

>>> src/dfu_core.sv
module dfu_core #(
	parameter int MAX_STUFFED_BYTES = dfu_pkg::MAX_STUFFED_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [dfu_pkg::BYTE_W-1:0] byte_s1,
	input  logic advance,
	output logic res_valid,
	output dfu_pkg::result_t res,
	output dfu_pkg::status_t status
);
	import dfu_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STUFFED_BYTES);

	logic hunting_q, escape_q;
	logic [CNT_W-1:0] stuffed_q, unstuffed_q;
	logic [SIZE_W-1:0] size_q;

	logic hunting_d, escape_d;
	logic [CNT_W-1:0] stuffed_d, unstuffed_d;
	logic [SIZE_W-1:0] size_d;
	logic size_ok;
	logic [BYTE_W-1:0] val;
	logic val_ok;

	assign size_ok = (size_q >= MIN_SIZE) &&
		({{(SIZE_W + 1 - CNT_W){1'b0}}, unstuffed_q} == ({1'b0, size_q} + SIZE_OVERHEAD));

	always_comb begin
		hunting_d = hunting_q;
		escape_d = escape_q;
		stuffed_d = stuffed_q;
		unstuffed_d = unstuffed_q;
		size_d = size_q;
		res_valid = 1'b0;
		res = '{kind: KIND_DATA, data_byte: '0, byte_index: '0, frame_length: '0};
		val = byte_s1;
		val_ok = 1'b0;
		if (hunting_q) begin
			if (byte_s1 == DELIM) begin
				hunting_d = 1'b0;
				escape_d = 1'b0;
				stuffed_d = '0;
				unstuffed_d = '0;
				size_d = '0;
			end
		end else if (stuffed_q >= MAX_CNT) begin
			// The byte that finds the buffer full is lost, delimiter or not.
			hunting_d = 1'b1;
			escape_d = 1'b0;
			stuffed_d = '0;
			unstuffed_d = '0;
			size_d = '0;
			res_valid = 1'b1;
			res.kind = KIND_OVERFLOW;
			res.frame_length = unstuffed_q;
		end else if (byte_s1 == DELIM) begin
			escape_d = 1'b0;
			stuffed_d = '0;
			unstuffed_d = '0;
			size_d = '0;
			res.frame_length = unstuffed_q;
			if (stuffed_q > MIN_STUFFED) begin
				res_valid = 1'b1;
				res.kind = size_ok ? KIND_GOOD : KIND_BAD_SIZE;
			end else if (stuffed_q != '0) begin
				res_valid = 1'b1;
				res.kind = KIND_SHORT;
			end
		end else begin
			stuffed_d = stuffed_q + 1'b1;
			if (escape_q) begin
				escape_d = 1'b0;
				if (byte_s1 == ESC_DELIM) begin
					val = DELIM;
					val_ok = 1'b1;
				end else if (byte_s1 == ESC_ESC) begin
					val = ESC;
					val_ok = 1'b1;
				end
			end else if (byte_s1 == ESC) begin
				escape_d = 1'b1;
			end else begin
				val_ok = 1'b1;
			end
			if (val_ok) begin
				if (unstuffed_q == 8'd0) begin
					size_d = {size_q[SIZE_W-1:BYTE_W], val};
				end else if (unstuffed_q == 8'd1) begin
					size_d = {val, size_q[BYTE_W-1:0]};
				end
				unstuffed_d = unstuffed_q + 1'b1;
				res_valid = 1'b1;
				res.kind = KIND_DATA;
				res.data_byte = val;
				res.byte_index = unstuffed_q[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			escape_q <= 1'b0;
			stuffed_q <= '0;
			unstuffed_q <= '0;
			size_q <= '0;
		end else if (advance) begin
			hunting_q <= hunting_d;
			escape_q <= escape_d;
			stuffed_q <= stuffed_d;
			unstuffed_q <= unstuffed_d;
			size_q <= size_d;
		end
	end

	assign status = '{hunting: hunting_q, escape_pending: escape_q,
		stuffed_count: stuffed_q, unstuffed_count: unstuffed_q};

endmodule

>>> src/dfu_out_reg.sv
module dfu_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  dfu_pkg::result_t res,
	output logic free,
	input  logic m_tready,
	output logic m_tvalid,
	output dfu_pkg::result_t res_q
);
	import dfu_pkg::*;

	logic valid_q;

	assign free = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

>>> src/delimited_frame_unstuffer.sv
// Delimited frame unstuffer: takes one received word per cycle on the s_ side while the
// sink takes results, hunts for the 0x12 delimiter, removes the 0xDB byte stuffing and sends
// every unstuffed byte out on the m_ side with its index in the frame, followed at a closing
// delimiter after a non-empty frame by one frame report (good, bad size or short) carrying
// the unstuffed length; a frame that reaches MAX_STUFFED_BYTES stuffed bytes is reported as
// overflow and the block hunts again. Each word passes through the input register and then
// the compare and counter logic into the result register, from which any result it yields
// is presented on the m_ side; a stalled sink stops the input after the input register has
// filled.
`include "delimited_frame_unstuffer_assert.svh"

module delimited_frame_unstuffer #(
	parameter int MAX_STUFFED_BYTES = dfu_pkg::MAX_STUFFED_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// Received bytes.
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	// Unstuffed bytes and frame reports.
	output logic m_tvalid,
	input  logic m_tready,
	output logic [23:0] m_tdata,  // [7:0] data_byte, [14:8] byte_index, [22:15] frame_length
	output logic [2:0] m_tuser    // [2:0] kind
);
	import dfu_pkg::*;

	// Input register: holds one received word until the core steps on it.
	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic advance;
	logic free;
	logic res_valid;
	result_t res;
	result_t res_q;
	status_t status;

	// The core steps whenever a word waits and the result register can take its result.
	assign advance = valid_s1 && free;
	assign s_tready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	dfu_core #(
		.MAX_STUFFED_BYTES(MAX_STUFFED_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.byte_s1(byte_s1),
		.advance(advance),
		.res_valid(res_valid),
		.res(res),
		.status(status)
	);

	dfu_out_reg u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && res_valid),
		.res(res),
		.free(free),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.res_q(res_q)
	);

	assign m_tdata = {1'b0, res_q.frame_length, res_q.byte_index, res_q.data_byte};
	assign m_tuser = res_q.kind;

	// A frame report never carries a data byte or index; a data word never a length.
	`DFU_ASSERT_NOW(a_report_fields, clk, arst_n, m_tvalid && (m_tuser != KIND_DATA),
		m_tdata[14:0] == 15'd0, "frame report carries data byte or index")
	`DFU_ASSERT_NOW(a_data_fields, clk, arst_n, m_tvalid && (m_tuser == KIND_DATA),
		m_tdata[22:15] == 8'd0, "data word carries a frame length")
	// Unstuffing never grows a frame, and the stuffed count never passes the buffer size.
	`DFU_ASSERT_NOW(a_counts, clk, arst_n, 1'b1,
		(status.unstuffed_count <= status.stuffed_count) &&
		(status.stuffed_count <= CNT_W'(MAX_STUFFED_BYTES)), "frame counters out of range")
	// While hunting nothing of a frame is held.
	`DFU_ASSERT_NOW(a_hunt_clear, clk, arst_n, status.hunting,
		(status.stuffed_count == '0) && !status.escape_pending, "frame state kept while hunting")
	// An overflow report always sends the core back to hunting.
	`DFU_ASSERT_NEXT(a_overflow_hunts, clk, arst_n, advance && res_valid &&
		(res.kind == KIND_OVERFLOW), status.hunting, "overflow did not restart the hunt")

endmodule
